[hdl/kdm_pkg.sv]
`timescale 1ns / 1ps
// kdm_pkg: shared types and constants of the kiwi drive wheel mixer
// no dependencies; used by kdm_mix and kiwi_drive_wheel_mixer

package kdm_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_COEF_THIRD      = 3'd0,
    CFG_COEF_SIDE       = 3'd1,
    CFG_COEF_TWO_THIRDS = 3'd2,
    CFG_NORM_LIMIT      = 3'd3,
    CFG_PWM_FULL        = 3'd4
  } cfg_reg_t;

  localparam int CMD_W    = 10;  // command field width
  localparam int COEF_W   = 14;  // q0.14 gain width
  localparam int LIM_W    = 8;   // norm limit / pwm full / duty width
  localparam int PROD_W   = 25;  // signed gain * command product
  localparam int SUM_W    = 26;  // signed wheel sum
  localparam int COARSE_W = 11;  // rounded sum / 16384
  localparam int MAG_W    = 9;   // rounded thrust magnitude
  localparam int CFG_W    = 14;  // config data width
  localparam int IDX_W    = 3;   // config index width

  // divide by 5 * 16384 with rounding: add half, shift by 14, then times 13108 >> 16
  localparam logic [SUM_W-1:0]  ROUND_HALF  = 26'd40960;
  localparam int                FRAC_SHIFT  = 14;
  localparam logic [COEF_W-1:0] RECIP_FIVE  = 14'd13108;
  localparam int                RECIP_SHIFT = 16;

  // register reset values
  localparam logic [COEF_W-1:0] RST_COEF_THIRD      = 14'd5461;
  localparam logic [COEF_W-1:0] RST_COEF_SIDE       = 14'd9460;
  localparam logic [COEF_W-1:0] RST_COEF_TWO_THIRDS = 14'd10923;
  localparam logic [LIM_W-1:0]  RST_NORM_LIMIT      = 8'd100;
  localparam logic [LIM_W-1:0]  RST_PWM_FULL        = 8'd255;

  // pipeline layout
  localparam int MIX_STG   = 4;                    // mix stages 0..3
  localparam int NORM_STG  = MIX_STG;              // normalize setup
  localparam int DIV_STG   = LIM_W / 2;            // two quotient bits per stage
  localparam int DIV1_STG  = NORM_STG + 1;         // first normalize divider stage
  localparam int PREP2_STG = DIV1_STG + DIV_STG;   // duty setup
  localparam int DIV2_STG  = PREP2_STG + 1;        // first duty divider stage
  localparam int NSTG      = DIV2_STG + DIV_STG;   // total stages

endpackage

[hdl/kdm_mix.sv]
`timescale 1ns / 1ps
// kdm_mix: four-stage mixer, gains times commands, wheel sums, rounded magnitude
// depends on kdm_pkg

module kdm_mix (
  input  logic                               clk,
  input  logic [kdm_pkg::MIX_STG-1:0]        adv,
  input  logic signed [kdm_pkg::CMD_W-1:0]   cmd_x,
  input  logic signed [kdm_pkg::CMD_W-1:0]   cmd_y,
  input  logic signed [kdm_pkg::CMD_W-1:0]   cmd_rot,
  input  logic [kdm_pkg::COEF_W-1:0]         coef_third,
  input  logic [kdm_pkg::COEF_W-1:0]         coef_side,
  input  logic [kdm_pkg::COEF_W-1:0]         coef_two_thirds,
  output logic [kdm_pkg::MAG_W-1:0]          mag_a,
  output logic [kdm_pkg::MAG_W-1:0]          mag_b,
  output logic [kdm_pkg::MAG_W-1:0]          mag_c,
  output logic [2:0]                         neg
);

  // stage 0: products
  logic signed [kdm_pkg::PROD_W-1:0] p_tx, p_sy, p_tr, p_kx;
  // stage 1: wheel sums
  logic signed [kdm_pkg::SUM_W-1:0] sum_a, sum_b, sum_c;
  // stage 2: coarse rounded magnitude and sign
  logic [kdm_pkg::COARSE_W-1:0] crs_a, crs_b, crs_c;
  logic [2:0] sgn;

  logic [kdm_pkg::SUM_W-1:0] abs_a, abs_b, abs_c;
  logic [kdm_pkg::SUM_W-1:0] rnd_a, rnd_b, rnd_c;
  logic [kdm_pkg::COARSE_W+kdm_pkg::COEF_W-1:0] rec_a, rec_b, rec_c;
  logic [kdm_pkg::MAG_W-1:0] q_a, q_b, q_c;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_tx <= $signed({1'b0, coef_third}) * cmd_x;
      p_sy <= $signed({1'b0, coef_side}) * cmd_y;
      p_tr <= $signed({1'b0, coef_third}) * cmd_rot;
      p_kx <= $signed({1'b0, coef_two_thirds}) * cmd_x;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sum_a <= kdm_pkg::SUM_W'(p_tx) + kdm_pkg::SUM_W'(p_sy) + kdm_pkg::SUM_W'(p_tr);
      sum_b <= kdm_pkg::SUM_W'(p_tx) - kdm_pkg::SUM_W'(p_sy) + kdm_pkg::SUM_W'(p_tr);
      sum_c <= kdm_pkg::SUM_W'(p_tr) - kdm_pkg::SUM_W'(p_kx);
    end
  end

  // magnitude, add half the divisor, drop the power-of-two part
  always_comb begin
    abs_a = sum_a[kdm_pkg::SUM_W-1] ? kdm_pkg::SUM_W'(-sum_a) : kdm_pkg::SUM_W'(sum_a);
    abs_b = sum_b[kdm_pkg::SUM_W-1] ? kdm_pkg::SUM_W'(-sum_b) : kdm_pkg::SUM_W'(sum_b);
    abs_c = sum_c[kdm_pkg::SUM_W-1] ? kdm_pkg::SUM_W'(-sum_c) : kdm_pkg::SUM_W'(sum_c);
    rnd_a = abs_a + kdm_pkg::ROUND_HALF;
    rnd_b = abs_b + kdm_pkg::ROUND_HALF;
    rnd_c = abs_c + kdm_pkg::ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      crs_a <= rnd_a[kdm_pkg::FRAC_SHIFT +: kdm_pkg::COARSE_W];
      crs_b <= rnd_b[kdm_pkg::FRAC_SHIFT +: kdm_pkg::COARSE_W];
      crs_c <= rnd_c[kdm_pkg::FRAC_SHIFT +: kdm_pkg::COARSE_W];
      sgn   <= {sum_c[kdm_pkg::SUM_W-1], sum_b[kdm_pkg::SUM_W-1], sum_a[kdm_pkg::SUM_W-1]};
    end
  end

  // divide by five through the reciprocal, exact below 16384
  always_comb begin
    rec_a = {{kdm_pkg::COEF_W{1'b0}}, crs_a} * {{kdm_pkg::COARSE_W{1'b0}}, kdm_pkg::RECIP_FIVE};
    rec_b = {{kdm_pkg::COEF_W{1'b0}}, crs_b} * {{kdm_pkg::COARSE_W{1'b0}}, kdm_pkg::RECIP_FIVE};
    rec_c = {{kdm_pkg::COEF_W{1'b0}}, crs_c} * {{kdm_pkg::COARSE_W{1'b0}}, kdm_pkg::RECIP_FIVE};
    q_a   = rec_a[kdm_pkg::RECIP_SHIFT +: kdm_pkg::MAG_W];
    q_b   = rec_b[kdm_pkg::RECIP_SHIFT +: kdm_pkg::MAG_W];
    q_c   = rec_c[kdm_pkg::RECIP_SHIFT +: kdm_pkg::MAG_W];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      mag_a <= q_a;
      mag_b <= q_b;
      mag_c <= q_c;
      // a thrust that rounds to zero has no direction
      neg   <= {sgn[2] && (q_c != '0), sgn[1] && (q_b != '0), sgn[0] && (q_a != '0)};
    end
  end

endmodule

[hdl/kdm_div.sv]
`timescale 1ns / 1ps
// kdm_div: pipelined three-lane restoring divider, two quotient bits per stage
// quotient must fit QW bits (numerator below divisor * 2**QW); depends on no package

module kdm_div #(
  parameter int NW = 17,  // numerator width
  parameter int DW = 9,   // divisor width
  parameter int QW = 8,   // quotient width, even
  parameter int SW = 3    // side bits carried along
) (
  input  logic            clk,
  input  logic [QW/2-1:0] adv,
  input  logic [NW-1:0]   num_a,
  input  logic [NW-1:0]   num_b,
  input  logic [NW-1:0]   num_c,
  input  logic [DW-1:0]   den,
  input  logic [SW-1:0]   side_in,
  output logic [QW-1:0]   quo_a,
  output logic [QW-1:0]   quo_b,
  output logic [QW-1:0]   quo_c,
  output logic [SW-1:0]   side_out
);

  localparam int STG = QW / 2;
  localparam int RW  = NW + DW;

  logic [NW-1:0] rem_i [STG][3];
  logic [NW-1:0] rem_q [STG][3];
  logic [QW-1:0] quo_i [STG][3];
  logic [QW-1:0] quo_q [STG][3];
  logic [DW-1:0] den_i [STG];
  logic [DW-1:0] den_q [STG];
  logic [SW-1:0] side_i [STG];
  logic [SW-1:0] side_q [STG];

  assign rem_i[0][0] = num_a;
  assign rem_i[0][1] = num_b;
  assign rem_i[0][2] = num_c;
  assign quo_i[0][0] = '0;
  assign quo_i[0][1] = '0;
  assign quo_i[0][2] = '0;
  assign den_i[0]    = den;
  assign side_i[0]   = side_in;

  genvar s, l;
  generate
    for (s = 0; s < STG; s++) begin : g_stg
      localparam int B1 = QW - 1 - 2 * s;
      localparam int B0 = QW - 2 - 2 * s;
      logic [DW-1:0] den_r;
      logic [SW-1:0] side_r;

      if (s > 0) begin : g_link
        for (l = 0; l < 3; l++) begin : g_ln
          assign rem_i[s][l] = rem_q[s-1][l];
          assign quo_i[s][l] = quo_q[s-1][l];
        end
        assign den_i[s]  = den_q[s-1];
        assign side_i[s] = side_q[s-1];
      end

      always_ff @(posedge clk) begin
        if (adv[s]) begin
          den_r  <= den_i[s];
          side_r <= side_i[s];
        end
      end
      assign den_q[s]  = den_r;
      assign side_q[s] = side_r;

      for (l = 0; l < 3; l++) begin : g_lane
        logic [RW-1:0] r_in, d_hi, d_lo, r_mid, r_out;
        logic          q_hi, q_lo;
        logic [NW-1:0] rem_r;
        logic [QW-1:0] quo_r;

        always_comb begin
          r_in  = {{DW{1'b0}}, rem_i[s][l]};
          d_hi  = {{NW{1'b0}}, den_i[s]} << B1;
          d_lo  = {{NW{1'b0}}, den_i[s]} << B0;
          q_hi  = (r_in >= d_hi);
          r_mid = q_hi ? r_in - d_hi : r_in;
          q_lo  = (r_mid >= d_lo);
          r_out = q_lo ? r_mid - d_lo : r_mid;
        end

        always_ff @(posedge clk) begin
          if (adv[s]) begin
            rem_r <= r_out[NW-1:0];
            quo_r <= {quo_i[s][l][QW-3:0], q_hi, q_lo};
          end
        end
        assign rem_q[s][l] = rem_r;
        assign quo_q[s][l] = quo_r;
      end
    end
  endgenerate

  assign quo_a    = quo_q[STG-1][0];
  assign quo_b    = quo_q[STG-1][1];
  assign quo_c    = quo_q[STG-1][2];
  assign side_out = side_q[STG-1];

endmodule

[hdl/kiwi_drive_wheel_mixer.sv]
`timescale 1ns / 1ps
// kiwi_drive_wheel_mixer: top level, config registers, stage control and normalization
// depends on kdm_pkg, kdm_mix, kdm_div
//
//  channel  dir  handshake          word
//  s_*      in   s_tvalid/s_tready  cmd_x, cmd_y, cmd_rot
//  m_*      out  m_tvalid/m_tready  dir_a..dir_c, pwm_a..pwm_c
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one command word per cycle while s_tready is high; 14 register stages from s_* to
// m_* (4 mix, 1 normalize setup, 4 normalize divide, 1 duty setup, 4 duty divide), set
// by the two 8-bit quotients resolved two bits a stage
// the last stage is the output register
// each stage moves when it is empty or the stages after it move, so bubbles close up
// and a stalled output still lets new words fill empty stages
// rst clears the stage valid bits and loads the register defaults; cfg_ready is always high

module kiwi_drive_wheel_mixer (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [9:0] cmd_x, [19:10] cmd_y, [29:20] cmd_rot, [31:30] zero
  // wheel stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [0] dir_a, [1] dir_b, [2] dir_c, [10:3] pwm_a,
                                  // [18:11] pwm_b, [26:19] pwm_c, [31:27] zero
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int N   = kdm_pkg::NSTG;
  localparam int LW  = kdm_pkg::LIM_W;
  localparam int MW  = kdm_pkg::MAG_W;
  localparam int CW  = kdm_pkg::CMD_W;
  localparam int N1W = MW + LW;   // normalize numerator
  localparam int N2W = 2 * LW;    // duty numerator

  // ---------------- configuration registers ----------------
  logic [kdm_pkg::COEF_W-1:0] coef_third, coef_side, coef_two_thirds;
  logic [LW-1:0]              norm_limit, pwm_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_third      <= kdm_pkg::RST_COEF_THIRD;
      coef_side       <= kdm_pkg::RST_COEF_SIDE;
      coef_two_thirds <= kdm_pkg::RST_COEF_TWO_THIRDS;
      norm_limit      <= kdm_pkg::RST_NORM_LIMIT;
      pwm_full        <= kdm_pkg::RST_PWM_FULL;
    end else if (cfg_valid && cfg_ready) begin
      case (kdm_pkg::cfg_reg_t'(cfg_index))
        kdm_pkg::CFG_COEF_THIRD:      coef_third      <= cfg_data;
        kdm_pkg::CFG_COEF_SIDE:       coef_side       <= cfg_data;
        kdm_pkg::CFG_COEF_TWO_THIRDS: coef_two_thirds <= cfg_data;
        kdm_pkg::CFG_NORM_LIMIT:      norm_limit      <= cfg_data[LW-1:0];
        kdm_pkg::CFG_PWM_FULL:        pwm_full        <= cfg_data[LW-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // ---------------- stage valid bits and advance ----------------
  logic [N-1:0] vld;
  logic [N-1:0] adv;

  // a stage may load when some stage at or after it is empty, or the output is taken
  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_adv
      assign adv[k] = m_tready || !(&vld[N-1:k]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (adv[i]) begin
          vld[i] <= (i == 0) ? s_tvalid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[N-1];

  // ---------------- mix stages ----------------
  logic [MW-1:0] mag_a, mag_b, mag_c;
  logic [2:0]    neg_mix;

  kdm_mix u_mix (
    .clk             (clk),
    .adv             (adv[kdm_pkg::MIX_STG-1:0]),
    .cmd_x           ($signed(s_tdata[CW-1:0])),
    .cmd_y           ($signed(s_tdata[2*CW-1:CW])),
    .cmd_rot         ($signed(s_tdata[3*CW-1:2*CW])),
    .coef_third      (coef_third),
    .coef_side       (coef_side),
    .coef_two_thirds (coef_two_thirds),
    .mag_a           (mag_a),
    .mag_b           (mag_b),
    .mag_c           (mag_c),
    .neg             (neg_mix)
  );

  // ---------------- normalize setup ----------------
  // largest magnitude; above the limit every wheel becomes w*limit/max,
  // otherwise it passes through the divider as w/1
  logic [MW-1:0]  mx_ab, mx;
  logic           scale;
  logic [N1W-1:0] pl_a, pl_b, pl_c;
  logic [N1W-1:0] n1_a, n1_b, n1_c;
  logic [MW-1:0]  d1;
  logic [2:0]     neg_n1;

  always_comb begin
    mx_ab = (mag_a > mag_b) ? mag_a : mag_b;
    mx    = (mag_c > mx_ab) ? mag_c : mx_ab;
    scale = mx > {1'b0, norm_limit};
    pl_a  = {{LW{1'b0}}, mag_a} * {{MW{1'b0}}, norm_limit};
    pl_b  = {{LW{1'b0}}, mag_b} * {{MW{1'b0}}, norm_limit};
    pl_c  = {{LW{1'b0}}, mag_c} * {{MW{1'b0}}, norm_limit};
  end

  always_ff @(posedge clk) begin
    if (adv[kdm_pkg::NORM_STG]) begin
      n1_a   <= scale ? pl_a : {{LW{1'b0}}, mag_a};
      n1_b   <= scale ? pl_b : {{LW{1'b0}}, mag_b};
      n1_c   <= scale ? pl_c : {{LW{1'b0}}, mag_c};
      d1     <= scale ? mx : MW'(1);
      neg_n1 <= neg_mix;
    end
  end

  logic [LW-1:0] w_a, w_b, w_c;
  logic [2:0]    neg_w;

  kdm_div #(.NW(N1W), .DW(MW), .QW(LW), .SW(3)) u_div_norm (
    .clk      (clk),
    .adv      (adv[kdm_pkg::PREP2_STG-1:kdm_pkg::DIV1_STG]),
    .num_a    (n1_a),
    .num_b    (n1_b),
    .num_c    (n1_c),
    .den      (d1),
    .side_in  (neg_n1),
    .quo_a    (w_a),
    .quo_b    (w_b),
    .quo_c    (w_c),
    .side_out (neg_w)
  );

  // ---------------- duty setup ----------------
  // duty = w*pwm_full/limit; a zero limit gives zero duty as 0/1
  logic           lim_zero;
  logic [N2W-1:0] n2_a, n2_b, n2_c;
  logic [LW-1:0]  d2;
  logic [2:0]     neg_n2;

  assign lim_zero = (norm_limit == '0);

  always_ff @(posedge clk) begin
    if (adv[kdm_pkg::PREP2_STG]) begin
      n2_a   <= lim_zero ? '0 : {{LW{1'b0}}, w_a} * {{LW{1'b0}}, pwm_full};
      n2_b   <= lim_zero ? '0 : {{LW{1'b0}}, w_b} * {{LW{1'b0}}, pwm_full};
      n2_c   <= lim_zero ? '0 : {{LW{1'b0}}, w_c} * {{LW{1'b0}}, pwm_full};
      d2     <= lim_zero ? LW'(1) : norm_limit;
      neg_n2 <= neg_w;
    end
  end

  logic [LW-1:0] pwm_a, pwm_b, pwm_c;
  logic [2:0]    dir;

  // last divider stage is the output register
  kdm_div #(.NW(N2W), .DW(LW), .QW(LW), .SW(3)) u_div_duty (
    .clk      (clk),
    .adv      (adv[N-1:kdm_pkg::DIV2_STG]),
    .num_a    (n2_a),
    .num_b    (n2_b),
    .num_c    (n2_c),
    .den      (d2),
    .side_in  (neg_n2),
    .quo_a    (pwm_a),
    .quo_b    (pwm_b),
    .quo_c    (pwm_c),
    .side_out (dir)
  );

  assign m_tdata = {5'b0, pwm_c, pwm_b, pwm_a, dir[2], dir[1], dir[0]};

  // ---------------- assertions ----------------
  // duty never exceeds the full-scale setting
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pwm_a <= pwm_full) && (pwm_b <= pwm_full) && (pwm_c <= pwm_full))
    else $error("duty value above pwm_full");

  // normalized magnitudes stay within the limit
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    vld[kdm_pkg::PREP2_STG-1] |->
      (w_a <= norm_limit) && (w_b <= norm_limit) && (w_c <= norm_limit))
    else $error("normalized thrust above norm_limit");

  // a stalled output never drops words from the pipeline
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    !m_tready |=> $countones(vld) >= $past($countones(vld)))
    else $error("word lost while output stalled");

endmodule
